FILE: rtl/energy_sorted_hit_list_defines.svh
// Assertion macros shared by the sorted hit list modules
`ifndef ENERGY_SORTED_HIT_LIST_DEFINES_SVH
`define ENERGY_SORTED_HIT_LIST_DEFINES_SVH
`ifndef ASSERT_OFF
`define ESHL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("eshl assertion failed");
`define ESHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eshl assertion failed");
`else
`define ESHL_ASSERT(label, clk, rst, prop)
`define ESHL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/eshl_pkg.sv
// Shared codes, widths and control structs of the sorted hit list
package eshl_pkg;

   localparam int ENERGY_W   = 24;
   localparam int TIME_W     = 32;
   localparam int POSITION_W = 16;
   localparam int CHANNEL_W  = 8;
   localparam int INDEX_W    = 4;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;

   localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] REQ_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd5;

   typedef struct packed {
      logic capture;
      logic compare;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

FILE: rtl/eshl_ctrl.sv
// Sequencer: capture, compare and apply steps of one request
`include "energy_sorted_hit_list_defines.svh"
module eshl_ctrl
   import eshl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CMP   = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!sts.out_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready  = (state_ff == S_IDLE);
   assign cmd.capture = req_tvalid && (state_ff == S_IDLE);
   assign cmd.compare = (state_ff == S_CMP);
   assign cmd.apply   = (state_ff == S_APPLY) && !sts.out_busy;

   `ESHL_ASSERT_NEXT(a_accept_to_cmp, clock, reset, cmd.capture, state_ff == S_CMP)
   `ESHL_ASSERT_NEXT(a_cmp_to_apply, clock, reset, state_ff == S_CMP, state_ff == S_APPLY)
   `ESHL_ASSERT_NEXT(a_apply_hold, clock, reset, (state_ff == S_APPLY) && sts.out_busy, state_ff == S_APPLY)

endmodule

FILE: rtl/eshl_datapath.sv
// Hit cells with parallel energy compare, shift-insert and result register
`include "energy_sorted_hit_list_defines.svh"
module eshl_datapath
   import eshl_pkg::*;
#(
   parameter int LIST_DEPTH = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [KIND_W-1:0]     req_type,
   input  logic [ENERGY_W-1:0]   hit_energy,
   input  logic [TIME_W-1:0]     hit_time,
   input  logic [POSITION_W-1:0] hit_position,
   input  logic [CHANNEL_W-1:0]  hit_channel,
   input  logic [INDEX_W-1:0]    read_index,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [STATUS_W-1:0]   status,
   output logic [SLOT_W-1:0]     slot,
   output logic [COUNT_W-1:0]    hit_count,
   output logic [ENERGY_W-1:0]   out_energy,
   output logic [TIME_W-1:0]     out_time,
   output logic [POSITION_W-1:0] out_position,
   output logic [CHANNEL_W-1:0]  out_channel
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int HW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int RW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic [KIND_W-1:0]     kind_ff;
   logic [ENERGY_W-1:0]   e_ff;
   logic [TIME_W-1:0]     t_ff;
   logic [POSITION_W-1:0] p_ff;
   logic [CHANNEL_W-1:0]  c_ff;
   logic [INDEX_W-1:0]    idx_ff;

   logic [LIST_DEPTH-1:0] gt_ff, gt_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [ENERGY_W-1:0]   energy_ff   [LIST_DEPTH];
   logic [TIME_W-1:0]     time_ff     [LIST_DEPTH];
   logic [POSITION_W-1:0] position_ff [LIST_DEPTH];
   logic [CHANNEL_W-1:0]  channel_ff  [LIST_DEPTH];

   logic [LIST_DEPTH-1:0] sel;
   logic [IDX_W-1:0]      pos;
   logic                  zero_e;
   logic                  full_rej;
   logic                  do_insert;
   logic [RW-1:0]         rd_idx;
   logic                  rd_ok;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COUNT_W-1:0]    hcount_ff, hcount_in;
   logic [ENERGY_W-1:0]   oe_ff, oe_in;
   logic [TIME_W-1:0]     ot_ff, ot_in;
   logic [POSITION_W-1:0] op_ff, op_in;
   logic [CHANNEL_W-1:0]  oc_ff, oc_in;
   logic                  produce;

   // hold request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_type;
         e_ff    <= hit_energy;
         t_ff    <= hit_time;
         p_ff    <= hit_position;
         c_ff    <= hit_channel;
         idx_ff  <= read_index;
      end
   end

   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         gt_in[i] = (CNT_W'(i) < count_ff) && (energy_ff[i] > e_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) gt_ff <= gt_in;
   end

   always_comb begin
      pos = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (i == 0) sel[i] = !gt_ff[i];
         else sel[i] = !gt_ff[i] && gt_ff[(i > 0) ? i - 1 : 0];
         if (sel[i]) pos = pos | IDX_W'(i);
      end
   end

   assign zero_e    = (e_ff == '0);
   assign full_rej  = &gt_ff;
   assign do_insert = cmd.apply && (kind_ff == REQ_INSERT) && !zero_e && !full_rej;
   assign rd_idx    = RW'(idx_ff);
   assign rd_ok     = rd_idx < RW'(count_ff);

   // advance cells below the insertion point, load the new hit at it
   always_ff @(posedge clock) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (do_insert) begin
            if (sel[i]) begin
               energy_ff[i]   <= e_ff;
               time_ff[i]     <= t_ff;
               position_ff[i] <= p_ff;
               channel_ff[i]  <= c_ff;
            end else if (!gt_ff[i] && (i > 0)) begin
               energy_ff[i]   <= energy_ff[(i > 0) ? i - 1 : 0];
               time_ff[i]     <= time_ff[(i > 0) ? i - 1 : 0];
               position_ff[i] <= position_ff[(i > 0) ? i - 1 : 0];
               channel_ff[i]  <= channel_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      produce   = 1'b0;
      status_in = ST_CLEARED;
      slot_in   = '0;
      oe_in     = '0;
      ot_in     = '0;
      op_in     = '0;
      oc_in     = '0;
      if (cmd.apply) begin
         case (kind_ff)
            REQ_CLEAR: begin
               produce   = 1'b1;
               count_in  = '0;
               status_in = ST_CLEARED;
            end
            REQ_INSERT: begin
               produce = 1'b1;
               if (zero_e) begin
                  status_in = ST_ZERO;
               end else if (full_rej) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_INSERTED;
                  slot_in   = SLOT_W'(SW'(pos));
                  if (count_ff < CNT_W'(LIST_DEPTH)) count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_READ: begin
               produce = 1'b1;
               slot_in = idx_ff;
               if (rd_ok) begin
                  status_in = ST_READ_OK;
                  oe_in     = energy_ff[rd_idx[IDX_W-1:0]];
                  ot_in     = time_ff[rd_idx[IDX_W-1:0]];
                  op_in     = position_ff[rd_idx[IDX_W-1:0]];
                  oc_in     = channel_ff[rd_idx[IDX_W-1:0]];
               end else begin
                  status_in = ST_READ_EMPTY;
               end
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end
      hcount_in    = COUNT_W'(HW'(count_in));
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         hcount_ff <= hcount_in;
         oe_ff     <= oe_in;
         ot_ff     <= ot_in;
         op_ff     <= op_in;
         oc_ff     <= oc_in;
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign status       = status_ff;
   assign slot         = slot_ff;
   assign hit_count    = hcount_ff;
   assign out_energy   = oe_ff;
   assign out_time     = ot_ff;
   assign out_position = op_ff;
   assign out_channel  = oc_ff;

   `ESHL_ASSERT(a_count_max, clock, reset, count_ff <= CNT_W'(LIST_DEPTH))
   `ESHL_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.apply && (kind_ff == REQ_CLEAR), count_ff == '0)
   `ESHL_ASSERT(a_read_nonzero, clock, reset, !(rsp_valid_ff && (status_ff == ST_READ_OK)) || (oe_ff != '0))

endmodule

FILE: rtl/energy_sorted_hit_list.sv
// A result is registered after its request passes the compare step, then the shift-insert step.
// A new request is taken only once the previous one has passed the compare and apply steps.
// A result waiting on rsp_tready holds the apply step; no request is taken until it applies.
// Reset is synchronous: it empties the list and clears the sequencer and result valid.
// Stored hits are not cleared by reset; only slots below the hit count are ever read.
module energy_sorted_hit_list
   import eshl_pkg::*;
#(
   parameter int LIST_DEPTH = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hit_energy[23:0], hit_time[55:24], hit_position[71:56], hit_channel[79:72],
   // read_index[83:80], zero fill[87:84]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot[3:0], hit_count[8:4], out_energy[32:9], out_time[64:33],
   // out_position[80:65], out_channel[88:81], zero fill[95:89]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   cmd_type               cmd;
   sts_type               sts;
   logic [SLOT_W-1:0]     slot;
   logic [COUNT_W-1:0]    hit_count;
   logic [ENERGY_W-1:0]   out_energy;
   logic [TIME_W-1:0]     out_time;
   logic [POSITION_W-1:0] out_position;
   logic [CHANNEL_W-1:0]  out_channel;

   eshl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   eshl_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req_tuser),
      .hit_energy   (req_tdata[23:0]),
      .hit_time     (req_tdata[55:24]),
      .hit_position (req_tdata[71:56]),
      .hit_channel  (req_tdata[79:72]),
      .read_index   (req_tdata[83:80]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .status       (rsp_tuser),
      .slot         (slot),
      .hit_count    (hit_count),
      .out_energy   (out_energy),
      .out_time     (out_time),
      .out_position (out_position),
      .out_channel  (out_channel)
   );

   assign rsp_tdata = {7'b0, out_channel, out_position, out_time, out_energy, hit_count, slot};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the energy-sorted hit list: table-driven and random requests
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import eshl_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_PER_PHASE = 200;
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_PLAN [4] = '{0, 46, 0, 30};
   localparam int STALL_PLAN [4] = '{0, 0, 46, 30};

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [ENERGY_W-1:0]   energy;
      logic [TIME_W-1:0]     stamp;
      logic [POSITION_W-1:0] position;
      logic [CHANNEL_W-1:0]  channel;
      logic [INDEX_W-1:0]    index;
   } hit_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_W-1:0]     slot;
      logic [COUNT_W-1:0]    count;
      logic [ENERGY_W-1:0]   energy;
      logic [TIME_W-1:0]     stamp;
      logic [POSITION_W-1:0] position;
      logic [CHANNEL_W-1:0]  channel;
   } hit_rsp_type;

   typedef struct packed {
      hit_req_type req;
      logic        fixed;
      hit_rsp_type rsp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // hit_energy, hit_time, hit_position, hit_channel, read_index, zero fill
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // req_type
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // slot, hit_count, out_energy, out_time, out_position, out_channel, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status
   logic [STATUS_W-1:0]   rsp_tuser;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;

   logic [ENERGY_W-1:0]   list_energy [DEPTH];
   logic [TIME_W-1:0]     list_stamp [DEPTH];
   logic [POSITION_W-1:0] list_position [DEPTH];
   logic [CHANNEL_W-1:0]  list_channel [DEPTH];
   logic [COUNT_W-1:0]    list_count = '0;

   hit_rsp_type  awaited_rsp [$];
   stim_row_type stim_rows [$];

   energy_sorted_hit_list #(
      .LIST_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Advance the sorted list by one request; returns 0 when no response follows
   function automatic bit list_step(input hit_req_type r, output hit_rsp_type rsp);
      int pos;
      int last;
      int j;
      rsp = '0;
      case (r.kind)
         REQ_CLEAR: begin
            list_count = '0;
            rsp.status = ST_CLEARED;
         end
         REQ_INSERT: begin
            if (r.energy == '0) begin
               rsp.status = ST_ZERO;
            end else begin
               pos = 0;
               while (pos < list_count && pos < DEPTH && list_energy[pos] > r.energy) pos++;
               if (pos >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  last = (list_count < DEPTH) ? int'(list_count) : DEPTH - 1;
                  for (j = last; j > pos; j--) begin
                     list_energy[j]   = list_energy[j-1];
                     list_stamp[j]    = list_stamp[j-1];
                     list_position[j] = list_position[j-1];
                     list_channel[j]  = list_channel[j-1];
                  end
                  list_energy[pos]   = r.energy;
                  list_stamp[pos]    = r.stamp;
                  list_position[pos] = r.position;
                  list_channel[pos]  = r.channel;
                  if (list_count < DEPTH) list_count++;
                  rsp.status = ST_INSERTED;
                  rsp.slot   = pos[SLOT_W-1:0];
               end
            end
         end
         REQ_READ: begin
            rsp.slot = r.index;
            if (r.index < list_count) begin
               rsp.status   = ST_READ_OK;
               rsp.energy   = list_energy[r.index];
               rsp.stamp    = list_stamp[r.index];
               rsp.position = list_position[r.index];
               rsp.channel  = list_channel[r.index];
            end else begin
               rsp.status = ST_READ_EMPTY;
            end
         end
         default: return 1'b0;
      endcase
      rsp.count = list_count;
      return 1'b1;
   endfunction

   function automatic hit_rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [COUNT_W-1:0] count,
                                            input logic [ENERGY_W-1:0] e,
                                            input logic [TIME_W-1:0] t,
                                            input logic [POSITION_W-1:0] p,
                                            input logic [CHANNEL_W-1:0] c);
      hit_rsp_type rsp;
      rsp = '{status, slot, count, e, t, p, c};
      return rsp;
   endfunction

   task automatic add_row(input logic [KIND_W-1:0] kind, input logic [ENERGY_W-1:0] e,
                          input logic [TIME_W-1:0] t, input logic [POSITION_W-1:0] p,
                          input logic [CHANNEL_W-1:0] c, input logic [INDEX_W-1:0] idx,
                          input logic fixed, input hit_rsp_type rsp);
      stim_row_type row;
      row.req   = '{kind, e, t, p, c, idx};
      row.fixed = fixed;
      row.rsp   = rsp;
      stim_rows.push_back(row);
   endtask

   // Mostly inserts with few clears, so runs reach a full list; small energies force ties
   function automatic hit_req_type random_request();
      hit_req_type r;
      int pick;
      r.stamp    = $urandom;
      r.position = 16'($urandom);
      r.channel  = 8'($urandom);
      r.index    = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 2) r.kind = REQ_CLEAR;
      else if (pick < 4) r.kind = REQ_UNUSED;
      else if (pick < 34) r.kind = REQ_READ;
      else r.kind = REQ_INSERT;
      pick = $urandom_range(99);
      if (pick < 3) r.energy = '0;
      else if (pick < 40) r.energy = 24'($urandom_range(8, 1));
      else if (pick < 50) r.energy = 24'hFFFFFF - 24'($urandom_range(3));
      else r.energy = 24'($urandom);
      if (r.kind == REQ_READ && list_count != 0 && $urandom_range(9) < 7)
         r.index = 4'($urandom_range(list_count - 1));
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input stim_row_type row);
      hit_rsp_type predicted;
      bit produces;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.req.kind;
      req_tdata  <= {4'b0, row.req.index, row.req.channel, row.req.position,
                     row.req.stamp, row.req.energy};
      do @(posedge clock); while (!req_tready);
      produces = list_step(row.req, predicted);
      if (produces) awaited_rsp.push_back(row.fixed ? row.rsp : predicted);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      hit_rsp_type got;
      hit_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[3:0], rsp_tdata[8:4], rsp_tdata[32:9],
                 rsp_tdata[64:33], rsp_tdata[80:65], rsp_tdata[88:81]};
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d slot %0d count %0d",
                        got.status, got.slot, got.count);
         end else begin
            want = awaited_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch exp/act: status %0d/%0d slot %0d/%0d count %0d/%0d ",
                            "energy %h/%h time %h/%h pos %h/%h chan %h/%h"},
                           want.status, got.status, want.slot, got.slot,
                           want.count, got.count, want.energy, got.energy,
                           want.stamp, got.stamp, want.position, got.position,
                           want.channel, got.channel);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type row;
      int sent;
      int phase;
      int k;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_row(REQ_READ, '0, '0, '0, '0, 4'h0, 1'b1,
              make_rsp(ST_READ_EMPTY, 4'd0, 5'd0, '0, '0, '0, '0));
      add_row(REQ_INSERT, '0, 32'h0000_1234, 16'h0042, 8'h11, 4'h0, 1'b1,
              make_rsp(ST_ZERO, 4'd0, 5'd0, '0, '0, '0, '0));
      add_row(REQ_UNUSED, '1, '1, '1, '1, '1, 1'b0, '0);
      add_row(REQ_INSERT, 24'hFFFFFF, 32'h7FFF_FFFF, 16'h7FFF, 8'hFF, 4'hF, 1'b1,
              make_rsp(ST_INSERTED, 4'd0, 5'd1, '0, '0, '0, '0));
      add_row(REQ_INSERT, 24'h000002, 32'h8000_0000, 16'h8000, 8'h00, 4'h0, 1'b1,
              make_rsp(ST_INSERTED, 4'd1, 5'd2, '0, '0, '0, '0));
      add_row(REQ_READ, '0, '0, '0, '0, 4'h0, 1'b1,
              make_rsp(ST_READ_OK, 4'd0, 5'd2, 24'hFFFFFF, 32'h7FFF_FFFF, 16'h7FFF, 8'hFF));
      add_row(REQ_READ, '0, '0, '0, '0, 4'hF, 1'b1,
              make_rsp(ST_READ_EMPTY, 4'd15, 5'd2, '0, '0, '0, '0));
      add_row(REQ_INSERT, 24'h000002, 32'hFFFF_FF00, 16'hFFFF, 8'h80, 4'h0, 1'b0, '0);
      for (k = 0; k < 13; k++)
         add_row(REQ_INSERT, 24'((k + 1) << 8), $urandom, 16'($urandom), 8'($urandom),
                 4'($urandom), 1'b0, '0);
      add_row(REQ_INSERT, 24'h200000, $urandom, 16'($urandom), 8'($urandom), 4'h0, 1'b0, '0);
      add_row(REQ_INSERT, 24'h000001, $urandom, 16'($urandom), 8'($urandom), 4'h0, 1'b1,
              make_rsp(ST_FULL, 4'd0, 5'd16, '0, '0, '0, '0));
      add_row(REQ_READ, '0, '0, '0, '0, 4'hF, 1'b0, '0);
      add_row(REQ_CLEAR, '0, '0, '0, '0, 4'h0, 1'b1,
              make_rsp(ST_CLEARED, 4'd0, 5'd0, '0, '0, '0, '0));

      foreach (stim_rows[i]) send_request(stim_rows[i]);
      drain_responses();

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = IDLE_PLAN[phase];
         rsp_stall_pct = STALL_PLAN[phase];
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            row = '0;
            row.req = random_request();
            send_request(row);
            if (row.req.kind != REQ_UNUSED) sent++;
         end
         drain_responses();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/eshl_pkg.sv
rtl/eshl_ctrl.sv
rtl/eshl_datapath.sv
rtl/energy_sorted_hit_list.sv
tb/tb.sv
